@@ hw/rtl/tlpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared sizes, codes and types for the two-level page table.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int unsigned UPPER_INDEX_BITS = 10;
  localparam int unsigned LOWER_INDEX_BITS = 10;
  localparam int unsigned POOL_TABLES      = 16;
  localparam int unsigned FRAME_BITS       = 20;

  localparam int unsigned PN_W     = 20;
  localparam int unsigned FRAME_IO_W = 20;
  localparam int unsigned PN_EXT_W = (UPPER_INDEX_BITS + LOWER_INDEX_BITS > PN_W) ?
                                     (UPPER_INDEX_BITS + LOWER_INDEX_BITS) : PN_W;

  localparam int unsigned L1_DEPTH = 1 << UPPER_INDEX_BITS;
  localparam int unsigned L2_DEPTH = 1 << LOWER_INDEX_BITS;
  localparam int unsigned L2_TOTAL = POOL_TABLES * L2_DEPTH;
  localparam int unsigned L2_AW    = $clog2(L2_TOTAL);

  localparam int unsigned IDX_W    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned POOL_CW  = $clog2(POOL_TABLES + 1);

  localparam int unsigned L1_W     = IDX_W + 1;
  localparam int unsigned L2_W     = FRAME_BITS + 1;

  localparam int unsigned CLR_COUNT = (L1_DEPTH > L2_TOTAL) ? L1_DEPTH : L2_TOTAL;
  localparam int unsigned CLR_W     = $clog2(CLR_COUNT);

  typedef enum logic {
    CMD_MAP    = 1'b0,
    CMD_LOOKUP = 1'b1
  } tlpt_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_TABLE   = 2'd1,
    STAT_UNMAPPED   = 2'd2,
    STAT_POOL_EMPTY = 2'd3
  } tlpt_status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_L1,
    S_L2
  } tlpt_state_e;

endpackage

@@ hw/rtl/tlpt_ram.sv @@
// ----------------------------------------------------------------------------
// tlpt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/two_level_page_table.sv @@
// ----------------------------------------------------------------------------
// two_level_page_table
// Map and lookup of virtual page numbers through a two-level table with a
// fixed pool of second-level tables.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over both RAMs (max of first-level
// depth and pool size times second-level depth, 16384 addresses here) with
// in_stall_o high. Then each word has its first-level read issued in S_IDLE
// and acted on in S_L1: a map, or a lookup that finds no second-level table,
// finishes in S_L1; a lookup that reaches a second-level table needs its
// dependent RAM read and finishes in S_L2. Words are handled one at a time; a
// finished result sits in the output register while the next word is accepted,
// and a stalled output holds the walk at its last step.
module two_level_page_table
  import tlpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [PN_W-1:0]       page_number_i,
  input  logic [FRAME_IO_W-1:0] frame_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [FRAME_IO_W-1:0] frame_out_o,
  output logic                  table_allocated_o
);

  tlpt_state_e state_q, state_d;
  logic [CLR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [POOL_CW-1:0] pool_used_q, pool_used_d;

  tlpt_cmd_e                   cmd_q, cmd_d;
  logic [LOWER_INDEX_BITS-1:0] lo_q, lo_d;
  logic [UPPER_INDEX_BITS-1:0] up_q, up_d;
  logic [FRAME_BITS-1:0]       frame_q, frame_d;

  logic                  out_valid_q, out_valid_d;
  tlpt_status_e          status_q, status_d;
  logic [FRAME_IO_W-1:0] frame_out_q, frame_out_d;
  logic                  alloc_q, alloc_d;

  logic                        l1_we, l1_re;
  logic [UPPER_INDEX_BITS-1:0] l1_waddr, l1_raddr;
  logic [L1_W-1:0]             l1_wdata, l1_rdata;
  logic                        l2_we, l2_re;
  logic [L2_AW-1:0]            l2_waddr, l2_raddr;
  logic [L2_W-1:0]             l2_wdata, l2_rdata;

  logic [PN_EXT_W-1:0]  pn_ext;
  logic                 can_emit;
  logic                 l1_present;
  logic [IDX_W-1:0]     l1_idx;
  logic [IDX_W-1:0]     new_idx;
  logic                 pool_full;

  tlpt_ram #(.Width(L1_W), .Depth(L1_DEPTH)) u_l1_ram (
    .clk_i   (clk_i),
    .we_i    (l1_we),
    .waddr_i (l1_waddr),
    .wdata_i (l1_wdata),
    .re_i    (l1_re),
    .raddr_i (l1_raddr),
    .rdata_o (l1_rdata)
  );

  tlpt_ram #(.Width(L2_W), .Depth(L2_TOTAL)) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (l2_waddr),
    .wdata_i (l2_wdata),
    .re_i    (l2_re),
    .raddr_i (l2_raddr),
    .rdata_o (l2_rdata)
  );

  assign pn_ext     = PN_EXT_W'(page_number_i);
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign l1_present = l1_rdata[IDX_W];
  assign l1_idx     = l1_rdata[IDX_W-1:0];
  assign new_idx    = IDX_W'(pool_used_q);
  assign pool_full  = (pool_used_q == POOL_CW'(POOL_TABLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      pool_used_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pool_used_q <= pool_used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    lo_q        <= lo_d;
    up_q        <= up_d;
    frame_q     <= frame_d;
    status_q    <= status_d;
    frame_out_q <= frame_out_d;
    alloc_q     <= alloc_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    pool_used_d = pool_used_q;
    cmd_d       = cmd_q;
    lo_d        = lo_q;
    up_d        = up_q;
    frame_d     = frame_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    frame_out_d = frame_out_q;
    alloc_d     = alloc_q;

    l1_we    = 1'b0;
    l1_waddr = up_q;
    l1_wdata = {1'b1, new_idx};
    l1_re    = 1'b0;
    l1_raddr = pn_ext[LOWER_INDEX_BITS +: UPPER_INDEX_BITS];
    l2_we    = 1'b0;
    l2_waddr = L2_AW'({l1_idx, lo_q});
    l2_wdata = {1'b1, frame_q};
    l2_re    = 1'b0;
    l2_raddr = L2_AW'({l1_idx, lo_q});

    unique case (state_q)
      S_CLEAR: begin
        l1_we     = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(L1_DEPTH));
        l1_waddr  = clr_cnt_q[UPPER_INDEX_BITS-1:0];
        l1_wdata  = '0;
        l2_we     = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(L2_TOTAL));
        l2_waddr  = clr_cnt_q[L2_AW-1:0];
        l2_wdata  = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_W'(CLR_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          l1_re   = 1'b1;
          cmd_d   = tlpt_cmd_e'(cmd_i);
          lo_d    = pn_ext[LOWER_INDEX_BITS-1:0];
          up_d    = pn_ext[LOWER_INDEX_BITS +: UPPER_INDEX_BITS];
          frame_d = FRAME_BITS'(frame_in_i);
          state_d = S_L1;
        end
      end
      S_L1: begin
        if (cmd_q == CMD_MAP) begin
          if (can_emit) begin
            out_valid_d = 1'b1;
            frame_out_d = '0;
            state_d     = S_IDLE;
            if (!l1_present && pool_full) begin
              status_d = STAT_POOL_EMPTY;
              alloc_d  = 1'b0;
            end else begin
              status_d = STAT_OK;
              l2_we    = 1'b1;
              if (!l1_present) begin
                l1_we       = 1'b1;
                l2_waddr    = L2_AW'({new_idx, lo_q});
                pool_used_d = pool_used_q + 1'b1;
                alloc_d     = 1'b1;
              end else begin
                alloc_d = 1'b0;
              end
            end
          end
        end else if (!l1_present) begin
          if (can_emit) begin
            out_valid_d = 1'b1;
            status_d    = STAT_NO_TABLE;
            frame_out_d = '0;
            alloc_d     = 1'b0;
            state_d     = S_IDLE;
          end
        end else begin
          l2_re   = 1'b1;
          state_d = S_L2;
        end
      end
      S_L2: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          alloc_d     = 1'b0;
          state_d     = S_IDLE;
          if (l2_rdata[FRAME_BITS]) begin
            status_d    = STAT_OK;
            frame_out_d = FRAME_IO_W'(l2_rdata[FRAME_BITS-1:0]);
          end else begin
            status_d    = STAT_UNMAPPED;
            frame_out_d = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign frame_out_o       = frame_out_q;
  assign table_allocated_o = alloc_q;

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_used_q <= POOL_CW'(POOL_TABLES))
    else $error("pool counter beyond pool size");

  a_pool_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pool_used_q != $past(pool_used_q)) |->
      (pool_used_q == $past(pool_used_q) + 1'b1) && $rose(out_valid_q || alloc_q)
      || (pool_used_q == $past(pool_used_q) + 1'b1) && alloc_q)
    else $error("pool counter moved without an allocation");

  a_alloc_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_allocated_o) |-> (status_o == STAT_OK) && (frame_out_o == '0))
    else $error("allocation reported with a fault or a frame");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (frame_out_o == '0) && !table_allocated_o)
    else $error("fault result carries a frame or an allocation");

  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_L1))
    else $error("accepted word did not start a walk");

endmodule
